>>> rtl/cgnb_pkg.sv
package cgnb_pkg;

    localparam int VALUE_BITS   = 31;
    localparam int CONTEXT_BITS = 16;
    localparam int POS_BITS     = $clog2(VALUE_BITS);

    // kind of pair the datapath builds on an emit command
    localparam logic [1:0] KIND_ONE  = 2'd0;   // unary prefix one
    localparam logic [1:0] KIND_ZERO = 2'd1;   // prefix terminator
    localparam logic [1:0] KIND_DATA = 2'd2;   // payload bit

    typedef struct packed {
        logic [VALUE_BITS-1:0]   value_to_code;
        logic [CONTEXT_BITS-1:0] context_base;
    } in_req_t;

    typedef struct packed {
        logic [CONTEXT_BITS-1:0] bit_context;
        logic                    coded_bit;
        logic                    last_of_run;
    } out_req_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [1:0] kind;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic more_unary;
        logic data_last;
    } sts_t;

endpackage

>>> rtl/cgnb_ctrl.sv
module cgnb_ctrl
    import cgnb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_UNARY = 2'd1;
    localparam logic [1:0] ST_DATA  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.kind   = KIND_ONE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_UNARY;
                end
            end
            ST_UNARY: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.more_unary) begin
                        cmd.kind = KIND_ONE;
                    end else begin
                        cmd.kind   = KIND_ZERO;
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_DATA;
                    if (sts.data_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/cgnb_dpath.sv
module cgnb_dpath
    import cgnb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  in_req_t  s_data,
    input  cmd_t     cmd,
    output sts_t     sts,
    output logic     m_valid,
    input  logic     m_ready,
    output out_req_t m_data
);

    logic [VALUE_BITS-1:0]   held_value_reg;
    logic [CONTEXT_BITS-1:0] held_base_reg;
    logic [POS_BITS-1:0]     pos_reg;
    logic [POS_BITS-1:0]     pos_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    out_req_t                out_reg;
    out_req_t                out_next;

    logic [POS_BITS:0]       shamt;
    logic [POS_BITS+1:0]     off_prefix;
    logic [POS_BITS+1:0]     off_data;

    // prefix test: (4 << i) <= value  <=>  value >> (i + 2) is nonzero
    assign shamt      = {1'b0, pos_reg} + (POS_BITS+1)'(2);
    assign off_prefix = {1'b0, pos_reg, 1'b0} + (POS_BITS+2)'(2);
    assign off_data   = {1'b0, pos_reg, 1'b1};

    assign sts.more_unary = (held_value_reg >> shamt) != '0;
    assign sts.data_last  = (pos_reg == '0);
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        pos_next     = pos_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.load) begin
            pos_next = '0;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            case (cmd.kind)
                KIND_ONE: begin
                    out_next.bit_context = held_base_reg + CONTEXT_BITS'(off_prefix);
                    out_next.coded_bit   = 1'b1;
                    out_next.last_of_run = 1'b0;
                    pos_next             = pos_reg + POS_BITS'(1);
                end
                KIND_ZERO: begin
                    out_next.bit_context = held_base_reg + CONTEXT_BITS'(off_prefix);
                    out_next.coded_bit   = 1'b0;
                    out_next.last_of_run = 1'b0;
                end
                KIND_DATA: begin
                    out_next.bit_context = held_base_reg + CONTEXT_BITS'(off_data);
                    out_next.coded_bit   = held_value_reg[pos_reg];
                    out_next.last_of_run = (pos_reg == '0);
                    if (pos_reg != '0) begin
                        pos_next = pos_reg - POS_BITS'(1);
                    end
                end
                default: begin
                    m_valid_next = m_valid_reg && !m_ready;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            held_value_reg <= s_data.value_to_code;
            held_base_reg  <= s_data.context_base;
        end
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> rtl/context_gamma_number_binarizer.sv
// Elias-gamma binarizer with per-position contexts.
//
// Input channel (s_valid/s_ready/s_data): one request carries a number and
// a base context. Result channel (m_valid/m_ready/m_data): one request per
// (context, bit) pair for the entropy coder; last_of_run marks the final
// pair of a number.
//
// A number with prefix length i (i ones, number < 4<<i) gives 2i+2 pairs:
// i ones and a zero at base+2k+2, then bits i..0 at base+2k+1.
// The first pair shows once the sequencer has left idle and the datapath
// has registered it; after that one pair per cycle while m_ready stays high.
// s_ready is high only while the sequencer is idle; it rises as soon as the
// last pair is in the output register, so the next number is taken while
// that pair still waits for the receiver.
// A stalled receiver holds the output register and freezes the sequencer;
// nothing is dropped.
// Reset (aresetn low, synchronous) empties the output register and
// returns the sequencer to idle.
module context_gamma_number_binarizer
    import cgnb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output out_req_t m_data
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: idle -> prefix (ones, then the zero) -> payload bits
    cgnb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // holds number, base and bit position; builds and registers each pair
    cgnb_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/cgnb_checker.sv
module cgnb_checker
    import cgnb_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input out_req_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one number at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken during a run");

    // a run in flight blocks new input
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_of_run |-> !s_ready)
        else $error("input ready before run finished");

    // reset empties output and idles sequencer
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

    // a request into an empty output shows its first pair after leaving idle
    a_first_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> ##1 m_valid)
        else $error("no pair after request");

endmodule

bind context_gamma_number_binarizer cgnb_checker u_cgnb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
